@@ sv/hash_message_padder_core_assert.svh @@
`ifndef HASH_MESSAGE_PADDER_CORE_ASSERT_SVH
`define HASH_MESSAGE_PADDER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define HMP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/hmp_pkg.sv @@
package hmp_pkg;

    typedef enum logic [2:0] {
        ST_DATA,
        ST_MARK,
        ST_ZERO,
        ST_LEN_HI,
        ST_LEN
    } state_t;

    typedef enum logic [1:0] {
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN
    } sel_t;

    typedef struct packed {
        logic take_item;
        logic load_word;
        sel_t word_sel;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic at_stop;
        logic wide;
    } status_t;

    localparam logic [1:0] MODE_MD5     = 2'd0;
    localparam logic [7:0] PAD_MARK     = 8'h80;
    localparam logic [3:0] STOP_IDX_64  = 4'd7;
    localparam logic [3:0] STOP_IDX_128 = 4'd14;

endpackage

@@ sv/hmp_datapath.sv @@
module hmp_datapath #(
    parameter int COUNT_BITS = 61
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        hash_mode,
    input  logic [7:0]        data_byte,
    input  logic              byte_valid,
    input  hmp_pkg::cmd_t     cmd,
    output hmp_pkg::status_t  status,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [63:0]       out_word,
    output logic              block_end,
    output logic              message_end
);

    logic [1:0]            mode_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [55:0]           partial_reg, partial_next;
    logic [3:0]            widx_reg, widx_next;
    logic                  valid_reg, valid_next;
    logic [63:0]           word_reg, word_next;
    logic                  block_end_reg, block_end_next;
    logic                  message_end_reg, message_end_next;

    logic                  wide;
    logic                  md5;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [63:0]           data_word;
    logic                  data_full;
    logic                  data_blk_end;
    logic [63:0]           mark_word;
    logic [63:0]           bits;
    logic [63:0]           bits_swap;
    logic [63:0]           len_word;
    logic [63:0]           pad_word;
    logic [3:0]            cur_idx;
    logic [3:0]            idx_inc;
    logic [3:0]            idx_wrap;

    assign wide         = mode_reg[1];
    assign md5          = (mode_reg == hmp_pkg::MODE_MD5);
    assign cnt_inc      = count_reg + 1'b1;
    assign data_word    = {partial_reg, data_byte};
    assign data_full    = (cnt_inc[2:0] == 3'b000);
    assign data_blk_end = wide ? (cnt_inc[6:0] == 7'd0) : (cnt_inc[5:0] == 6'd0);
    assign mark_word    = {partial_reg, hmp_pkg::PAD_MARK} << {~count_reg[2:0], 3'b000};
    assign bits         = 64'({count_reg, 3'b000});

    // md5 length goes out little-endian
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            bits_swap[63 - 8 * i -: 8] = bits[8 * i +: 8];
        end
    end

    assign len_word = md5 ? bits_swap : bits;
    assign cur_idx  = (cmd.word_sel == hmp_pkg::SEL_MARK) ? count_reg[6:3] : widx_reg;
    assign idx_inc  = cur_idx + 4'd1;
    assign idx_wrap = wide ? idx_inc : {1'b0, idx_inc[2:0]};

    always_comb
    begin
        unique case (cmd.word_sel)
            hmp_pkg::SEL_MARK: pad_word = mark_word;
            hmp_pkg::SEL_LEN:  pad_word = len_word;
            default:           pad_word = '0;
        endcase
    end

    always_comb
    begin
        count_next       = count_reg;
        partial_next     = partial_reg;
        widx_next        = widx_reg;
        valid_next       = valid_reg;
        word_next        = word_reg;
        block_end_next   = block_end_reg;
        message_end_next = message_end_reg;

        if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end

        if (cmd.take_item && byte_valid)
        begin
            count_next = cnt_inc;
            if (data_full)
            begin
                partial_next     = '0;
                valid_next       = 1'b1;
                word_next        = data_word;
                block_end_next   = data_blk_end;
                message_end_next = 1'b0;
            end
            else
            begin
                partial_next = data_word[55:0];
            end
        end
        else if (cmd.load_word)
        begin
            valid_next       = 1'b1;
            word_next        = pad_word;
            block_end_next   = (idx_wrap == 4'd0);
            message_end_next = (cmd.word_sel == hmp_pkg::SEL_LEN);
            widx_next        = idx_wrap;
            if (cmd.word_sel == hmp_pkg::SEL_MARK)
            begin
                partial_next = '0;
            end
            if (cmd.word_sel == hmp_pkg::SEL_LEN)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= hmp_pkg::MODE_MD5;
            count_reg   <= '0;
            partial_reg <= '0;
            widx_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                mode_reg <= hash_mode;
            end
            count_reg   <= count_next;
            partial_reg <= partial_next;
            widx_reg    <= widx_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg        <= word_next;
        block_end_reg   <= block_end_next;
        message_end_reg <= message_end_next;
    end

    assign status.out_free = !valid_reg || !out_stall;
    assign status.at_stop  = (widx_reg == (wide ? hmp_pkg::STOP_IDX_128
                                                : hmp_pkg::STOP_IDX_64));
    assign status.wide     = wide;

    assign out_valid   = valid_reg;
    assign out_word    = word_reg;
    assign block_end   = block_end_reg;
    assign message_end = message_end_reg;

endmodule

@@ sv/hmp_ctrl.sv @@
module hmp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              end_of_message,
    output logic              in_stall,
    input  hmp_pkg::status_t  status,
    output hmp_pkg::cmd_t     cmd
);

    hmp_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hmp_pkg::ST_DATA;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_stall      = 1'b1;
        cmd.take_item = 1'b0;
        cmd.load_word = 1'b0;
        cmd.word_sel  = hmp_pkg::SEL_ZERO;

        unique case (state_reg)
            hmp_pkg::ST_DATA:
            begin
                in_stall = !status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.take_item = 1'b1;
                    if (end_of_message)
                    begin
                        state_next = hmp_pkg::ST_MARK;
                    end
                end
            end
            hmp_pkg::ST_MARK:
            begin
                cmd.word_sel = hmp_pkg::SEL_MARK;
                if (status.out_free)
                begin
                    cmd.load_word = 1'b1;
                    state_next    = hmp_pkg::ST_ZERO;
                end
            end
            hmp_pkg::ST_ZERO:
            begin
                if (status.at_stop)
                begin
                    state_next = status.wide ? hmp_pkg::ST_LEN_HI : hmp_pkg::ST_LEN;
                end
                else if (status.out_free)
                begin
                    cmd.load_word = 1'b1;
                end
            end
            hmp_pkg::ST_LEN_HI:
            begin
                // upper half of the 128-bit length is zero
                if (status.out_free)
                begin
                    cmd.load_word = 1'b1;
                    state_next    = hmp_pkg::ST_LEN;
                end
            end
            hmp_pkg::ST_LEN:
            begin
                cmd.word_sel = hmp_pkg::SEL_LEN;
                if (status.out_free)
                begin
                    cmd.load_word = 1'b1;
                    state_next    = hmp_pkg::ST_DATA;
                end
            end
            default:
            begin
                state_next = hmp_pkg::ST_DATA;
            end
        endcase
    end

endmodule

@@ sv/hash_message_padder_core.sv @@
// Merkle-Damgard message padder for MD5, SHA-256 and SHA-512.
// Input channel (in_valid / in_stall): one request per message byte with
// byte_valid and end_of_message; end_of_message with byte_valid low closes
// the message without a byte, byte_valid low without it is a no-op.
// Output channel (out_valid / out_stall): 64-bit words, earliest byte in
// bits 63:56, block_end on the last word of each block, message_end on the
// last word of the padded message.
// Config channel (cfg_valid / cfg_ready): writes hash_mode, 0 md5, 1 sha-256,
// 2 or 3 sha-512; write only while no message is in flight.
// Throughput: one byte per cycle while the output register is free; a data
// word is registered and appears in the cycle after its eighth byte is accepted.
// Padding: after the closing request the input stalls while the controller
// emits 2 to 18 words, one per cycle while the output register is free, plus
// a step with no word before the length words; the output register is the
// only buffer. A stalled output holds its word and also stalls the input.
// Reset: mode md5, byte count and partial word cleared, output empty.
module hash_message_padder_core #(
    parameter int COUNT_BITS = 61
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  hash_mode,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] out_word,
    output logic        block_end,
    output logic        message_end
);

    hmp_pkg::cmd_t    cmd;
    hmp_pkg::status_t status;

    assign cfg_ready = 1'b1;

    hmp_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .end_of_message (end_of_message),
        .in_stall       (in_stall),
        .status         (status),
        .cmd            (cmd)
    );

    hmp_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .hash_mode   (hash_mode),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .cmd         (cmd),
        .status      (status),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_word    (out_word),
        .block_end   (block_end),
        .message_end (message_end)
    );

endmodule

@@ sv/hmp_checker.sv @@
`include "hash_message_padder_core_assert.svh"

module hmp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] out_word,
    input logic        block_end,
    input logic        message_end
);

    // a stalled word holds
    `HMP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")

    // the last word always closes a block
    `HMP_ASSERT_NOW(a_end_closes_block, out_valid && message_end, block_end, "message_end without block_end")

    // no request taken while the output register is blocked
    `HMP_ASSERT_NOW(a_no_take_when_full, out_valid && out_stall, in_stall, "input taken while output full")

    // input reopens as the final word leaves
    `HMP_ASSERT_NOW(a_reopen_after_end, out_valid && !out_stall && message_end, !in_stall, "input not reopened after message end")

endmodule

bind hash_message_padder_core hmp_checker u_hmp_checker (.*);

@@ sim/hash_message_padder_checker.sv @@
`timescale 1ns / 1ps

package hmp_mode_pkg;

    localparam logic [1:0] MODE_SHA256     = 2'd1;
    localparam logic [1:0] MODE_SHA512     = 2'd2;
    localparam logic [1:0] MODE_SHA512_ALT = 2'd3;

endpackage

module hash_message_padder_checker #(
    parameter int COUNT_BITS = 61
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  hash_mode,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] out_word,
    input  logic        block_end,
    input  logic        message_end,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [63:0] word;
        logic        blk_end;
        logic        msg_end;
    } padded_word_t;

    padded_word_t            expected_words[$];
    logic [COUNT_BITS-1:0]   msg_bytes = '0;
    logic [63:0]             gather = '0;
    logic [1:0]              cur_mode = hmp_pkg::MODE_MD5;
    int unsigned             pad_pos;
    int unsigned             pad_blk;
    int                      err_count = 0;

    task automatic push_word(input logic [63:0] w, input logic be, input logic me);
        padded_word_t e;
        e.word = w;
        e.blk_end = be;
        e.msg_end = me;
        expected_words.push_back(e);
    endtask

    task automatic pad_byte(input logic [7:0] b, input logic last);
        gather = {gather[55:0], b};
        pad_pos = (pad_pos + 1) & (pad_blk - 1);
        if ((pad_pos & 7) == 0)
        begin
            push_word(gather, pad_pos == 0, last);
            gather = '0;
        end
    endtask

    task automatic predict_item(input logic [7:0] d, input logic bv, input logic eom);
        int unsigned stop;
        logic [63:0] bit_len;
        pad_blk = (cur_mode >= hmp_mode_pkg::MODE_SHA512) ? 128 : 64;
        if (bv)
        begin
            gather = {gather[55:0], d};
            msg_bytes = msg_bytes + 1'b1;
            if (msg_bytes[2:0] == 3'd0)
            begin
                push_word(gather, (int'(msg_bytes[6:0]) & (pad_blk - 1)) == 0, 1'b0);
                gather = '0;
            end
        end
        if (eom)
        begin
            pad_pos = int'(msg_bytes[6:0]) & (pad_blk - 1);
            stop = (pad_blk == 128) ? 112 : 56;
            bit_len = 64'(msg_bytes) << 3;
            pad_byte(hmp_pkg::PAD_MARK, 1'b0);
            while (pad_pos != stop)
                pad_byte(8'h00, 1'b0);
            if (cur_mode == hmp_pkg::MODE_MD5)
            begin
                for (int i = 0; i < 8; i++)
                    pad_byte(bit_len[8*i +: 8], i == 7);
            end
            else
            begin
                // upper half of the 128-bit length is zero
                if (pad_blk == 128)
                    repeat (8) pad_byte(8'h00, 1'b0);
                for (int i = 7; i >= 0; i--)
                    pad_byte(bit_len[8*i +: 8], i == 0);
            end
            msg_bytes = '0;
            gather = '0;
        end
    endtask

    always @(posedge clk)
    begin : compare
        padded_word_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                cur_mode = hash_mode;
            if (in_valid && !in_stall)
                predict_item(data_byte, byte_valid, end_of_message);
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected output word %h be %b me %b",
                                 out_word, block_end, message_end);
                    err_count++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.word !== out_word || want.blk_end !== block_end ||
                        want.msg_end !== message_end)
                    begin
                        if (err_count < 10)
                            $display("output mismatch: expected %h be %b me %b, got %h be %b me %b",
                                     want.word, want.blk_end, want.msg_end,
                                     out_word, block_end, message_end);
                        err_count++;
                    end
                end
            end
        end
        mismatches <= err_count;
        outstanding <= expected_words.size();
    end

endmodule

@@ sim/hash_message_padder_core_test.sv @@
`timescale 1ns / 1ps

module hash_message_padder_core_test;

    localparam int IDLE_LIMIT = 2000;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  hash_mode = hmp_pkg::MODE_MD5;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_valid = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_stall = 1'b0;
    wire         cfg_ready;
    wire         in_stall;
    wire         out_valid;
    wire  [63:0] out_word;
    wire         block_end;
    wire         message_end;

    int mismatches;
    int outstanding;
    int burst_left = 0;
    int idle_cycles = 0;
    int items_sent = 0;
    int stall_left = 0;
    int stall_style = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    hash_message_padder_core #(
        .COUNT_BITS(61)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .hash_mode(hash_mode),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .byte_valid(byte_valid),
        .end_of_message(end_of_message),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word),
        .block_end(block_end),
        .message_end(message_end)
    );

    hash_message_padder_checker #(
        .COUNT_BITS(61)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .hash_mode(hash_mode),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .byte_valid(byte_valid),
        .end_of_message(end_of_message),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word),
        .block_end(block_end),
        .message_end(message_end),
        .mismatches(mismatches),
        .outstanding(outstanding)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // output back-pressure: free, light or heavy stretches
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style <= $urandom_range(0, 2);
            stall_left <= $urandom_range(8, 60);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic send_item(input logic [7:0] d, input logic bv, input logic eom);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        data_byte <= d;
        byte_valid <= bv;
        end_of_message <= eom;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained;
        in_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        wait_drained();
        cfg_valid <= 1'b1;
        hash_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_message(input int len);
        logic close_empty;
        close_empty = (len == 0) || ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            // stray idle request inside the message
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !close_empty);
        end
        if (close_empty)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int r;
        int len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mode, idle request, empty message, one byte
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);

        write_mode(hmp_mode_pkg::MODE_SHA256);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);

        write_mode(hmp_mode_pkg::MODE_SHA512);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);

        write_mode(hmp_mode_pkg::MODE_SHA512_ALT);
        send_item(8'h12, 1'b1, 1'b0);
        send_item(8'h34, 1'b1, 1'b0);
        send_item(8'h56, 1'b1, 1'b1);

        // mode switch inside a message
        write_mode(hmp_pkg::MODE_MD5);
        for (int i = 0; i < 8; i++)
            send_item(8'(i * 37), 1'b1, 1'b0);
        write_mode(hmp_mode_pkg::MODE_SHA256);
        send_item(8'hC3, 1'b1, 1'b0);
        send_item(8'h3C, 1'b1, 1'b1);

        while (items_sent < 150)
        begin
            if ($urandom_range(0, 2) == 0)
                write_mode(2'($urandom_range(0, 3)));
            r = $urandom_range(0, 99);
            if (r < 75)
                len = $urandom_range(0, 12);
            else if (r < 92)
                len = $urandom_range(52, 60);
            else
                len = $urandom_range(108, 116);
            send_message(len);
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/hmp_pkg.sv
sv/hmp_datapath.sv
sv/hmp_ctrl.sv
sv/hash_message_padder_core.sv
sv/hmp_checker.sv
sim/hash_message_padder_checker.sv
sim/hash_message_padder_core_test.sv
